// ===== src/gnfd_pkg.sv =====
package gnfd_pkg;

  // Default sizes
  localparam int unsigned FEAT_DIM_DEF   = 512;
  localparam int unsigned MAX_ROWS_DEF   = 128;
  localparam int unsigned MAX_TRACKS_DEF = 64;

  // Field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned DIST_W   = 36;
  localparam int unsigned BUDGET_W = 8;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 48;

  // Register reset values and fixed-point one (Q.30)
  localparam logic                MODE_RESET   = 1'b1;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 8'd100;
  localparam int unsigned         FRAC_BITS    = 30;

  typedef enum logic [KIND_W-1:0] {
    KIND_GAL  = 2'd0,
    KIND_QRY  = 2'd1,
    KIND_REQ  = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_MODE   = 1'b0,
    CFG_BUDGET = 1'b1
  } cfg_reg_e;

  // One classified item between front and back
  typedef struct packed {
    kind_e                   kind;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       slot;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    last_elem;
  } item_t;

endpackage

// ===== src/gnfd_ram.sv =====
module gnfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gnfd_front.sv =====
module gnfd_front #(
  parameter int unsigned FEAT_DIM   = gnfd_pkg::FEAT_DIM_DEF,
  parameter int unsigned MAX_TRACKS = gnfd_pkg::MAX_TRACKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gnfd_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic [gnfd_pkg::KIND_W-1:0]   s_axis_tuser,
  input  logic                          s_axis_tlast,
  input  logic                          pop_i,
  output gnfd_pkg::item_t               head_o,
  output logic                          head_valid_o
);

  localparam int unsigned QD = 2;

  gnfd_pkg::item_t item;
  logic            idx_ok;
  logic            keep;
  logic            push;
  gnfd_pkg::item_t fifo_q [QD];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  // Unpack and classify
  always_comb begin
    item.kind      = gnfd_pkg::kind_e'(s_axis_tuser);
    item.slot      = s_axis_tdata[5:0];
    item.idx       = s_axis_tdata[14:6];
    item.val       = s_axis_tdata[30:15];
    item.last_elem = s_axis_tlast;
    item.slot_ok   = 32'(item.slot) < 32'(MAX_TRACKS);
    idx_ok         = 32'(item.idx) < 32'(FEAT_DIM);
    unique case (item.kind)
      gnfd_pkg::KIND_GAL:  keep = item.slot_ok && idx_ok;
      gnfd_pkg::KIND_QRY:  keep = idx_ok;
      gnfd_pkg::KIND_DROP: keep = item.slot_ok;
      gnfd_pkg::KIND_REQ:  keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'(QD));
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign head_valid_o  = (cnt_q != 2'd0);
  assign head_o        = fifo_q[rptr_q];

  // Advance queue pointers
  always_comb begin
    wptr_d = push  ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= item;
    end
  end

endmodule

// ===== src/gnfd_back.sv =====
module gnfd_back #(
  parameter int unsigned FEAT_DIM   = gnfd_pkg::FEAT_DIM_DEF,
  parameter int unsigned MAX_ROWS   = gnfd_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_TRACKS = gnfd_pkg::MAX_TRACKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [gnfd_pkg::BUDGET_W-1:0]   cfg_data_i,
  input  gnfd_pkg::item_t                 head_i,
  input  logic                            head_valid_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gnfd_pkg::M_DATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser
);

  localparam int unsigned EW    = $clog2(FEAT_DIM);
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned MW    = CW + RW;
  localparam int unsigned GAW   = TW + RW + EW;
  localparam int unsigned PW    = 2 * (gnfd_pkg::VAL_W + 1);
  localparam int unsigned ACC_W = PW + EW + 1;
  localparam int unsigned D_W   = ACC_W + 1;
  localparam int unsigned DW    = gnfd_pkg::DIST_W;
  localparam logic signed [D_W-1:0] ONE_Q30 = D_W'(1) << gnfd_pkg::FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GMETA = 5'b00010,
    S_RMETA = 5'b00100,
    S_RUN   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_e;

  typedef struct packed {
    logic vld;
    logic first_e;
    logic last_e;
    logic last_row;
  } tap_t;

  state_e                  state_q, state_d;
  gnfd_pkg::item_t         cur_q, cur_d;
  logic                    mode_q;
  logic [gnfd_pkg::BUDGET_W-1:0] budget_q;
  logic [CW-1:0]           eff_b;
  logic [MAX_TRACKS-1:0]   valid_q, valid_d;
  logic                    meta_vld_q;
  logic                    meta_re, meta_we;
  logic [TW-1:0]           meta_raddr;
  logic [MW-1:0]           meta_wdata, meta_rdata;
  logic [CW-1:0]           cnt_s;
  logic [RW-1:0]           wr_s, wr_n;
  logic [CW-1:0]           cnt_n;
  logic                    gal_we, gal_re;
  logic [GAW-1:0]          gal_waddr, gal_raddr;
  logic [gnfd_pkg::VAL_W-1:0] gal_rdata, qry_rdata;
  logic                    qry_we;
  logic [RW-1:0]           row_q, row_d;
  logic [EW-1:0]           e_q, e_d;
  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           n_s;
  tap_t                    tap0, t1_q, t2_q, t3_q;
  logic signed [PW/2-1:0]  op_a, op_b;
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [D_W-1:0]   row_d_val, new_best, best_q;
  logic                    best_vld_q;
  logic [D_W-DW:0]         hi_bits;
  logic [DW-1:0]           best_sat;
  logic                    out_load, out_valid_q, out_empty_n, out_empty_q;
  logic [DW-1:0]           out_dist_n, out_dist_q;
  logic [gnfd_pkg::SLOT_W-1:0] out_slot_n, out_slot_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gnfd_pkg::MODE_RESET;
      budget_q <= gnfd_pkg::BUDGET_RESET;
    end else if (cfg_valid_i) begin
      unique case (gnfd_pkg::cfg_reg_e'(cfg_index_i))
        gnfd_pkg::CFG_MODE:   mode_q   <= cfg_data_i[0];
        gnfd_pkg::CFG_BUDGET: budget_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp budget to 1 .. MAX_ROWS
  always_comb begin
    priority if (budget_q == '0) eff_b = CW'(1);
    else if (9'(budget_q) > 9'(MAX_ROWS)) eff_b = CW'(MAX_ROWS);
    else eff_b = CW'(budget_q);
  end

  // Track metadata; an entry without its valid bit reads as zero
  assign {cnt_s, wr_s} = meta_vld_q ? meta_rdata : '0;
  assign n_s = (cnt_s > eff_b) ? eff_b : cnt_s;

  // Gallery commit arithmetic
  always_comb begin
    logic [RW-1:0] wr;
    wr = (CW'(wr_s) >= eff_b) ? '0 : wr_s;
    wr_n  = wr;
    cnt_n = cnt_s;
    if (cur_q.last_elem) begin
      wr_n  = ((CW'(wr) + CW'(1)) >= eff_b) ? '0 : wr + RW'(1);
      cnt_n = (cnt_s < eff_b) ? cnt_s + CW'(1) : eff_b;
    end
    gal_waddr = {TW'(cur_q.slot), wr, EW'(cur_q.idx)};
  end

  // Row distance, running minimum and saturation
  always_comb begin
    row_d_val = mode_q ? (ONE_Q30 - D_W'(acc_q)) : D_W'(acc_q);
    new_best  = (!best_vld_q || row_d_val < best_q) ? row_d_val : best_q;
    hi_bits   = new_best[D_W-1:DW-1];
    if ((hi_bits == '0) || (hi_bits == '1)) best_sat = new_best[DW-1:0];
    else if (new_best[D_W-1]) best_sat = {1'b1, {(DW-1){1'b0}}};
    else best_sat = {1'b0, {(DW-1){1'b1}}};
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    pop_o       = 1'b0;
    meta_re     = 1'b0;
    meta_raddr  = TW'(head_i.slot);
    meta_we     = 1'b0;
    meta_wdata  = {cnt_n, wr_n};
    valid_d     = valid_q;
    gal_we      = 1'b0;
    gal_re      = 1'b0;
    qry_we      = 1'b0;
    row_d       = row_q;
    e_d         = e_q;
    n_d         = n_q;
    out_load    = 1'b0;
    out_empty_n = 1'b1;
    out_dist_n  = '0;
    out_slot_n  = cur_q.slot;
    tap0        = '0;
    gal_raddr   = {TW'(cur_q.slot), row_q, e_q};
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i && (head_i.kind != gnfd_pkg::KIND_REQ || !out_valid_q)) begin
          pop_o = 1'b1;
          cur_d = head_i;
          unique case (head_i.kind)
            gnfd_pkg::KIND_QRY:  qry_we = 1'b1;
            gnfd_pkg::KIND_DROP: valid_d[TW'(head_i.slot)] = 1'b0;
            gnfd_pkg::KIND_GAL: begin
              meta_re = 1'b1;
              state_d = S_GMETA;
            end
            gnfd_pkg::KIND_REQ: begin
              if (head_i.slot_ok) begin
                meta_re = 1'b1;
                state_d = S_RMETA;
              end else begin
                out_load   = 1'b1;
                out_slot_n = head_i.slot;
              end
            end
            default: ;
          endcase
        end
      end
      S_GMETA: begin
        gal_we     = 1'b1;
        meta_we    = 1'b1;
        meta_raddr = TW'(cur_q.slot);
        valid_d[TW'(cur_q.slot)] = 1'b1;
        state_d    = S_IDLE;
      end
      S_RMETA: begin
        if (n_s == '0) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          n_d     = n_s;
          row_d   = '0;
          e_d     = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        gal_re        = 1'b1;
        tap0.vld      = 1'b1;
        tap0.first_e  = (e_q == '0);
        tap0.last_e   = (e_q == EW'(FEAT_DIM - 1));
        tap0.last_row = ((CW'(row_q) + CW'(1)) == n_q);
        e_d           = tap0.last_e ? '0 : e_q + EW'(1);
        if (tap0.last_e) begin
          row_d = row_q + RW'(1);
          if (tap0.last_row) state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (t3_q.vld && t3_q.last_e && t3_q.last_row) begin
          out_load    = 1'b1;
          out_empty_n = 1'b0;
          out_dist_n  = best_sat;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operands of the product stage
  always_comb begin
    if (mode_q) begin
      op_a = (PW/2)'($signed(gal_rdata));
      op_b = (PW/2)'($signed(qry_rdata));
    end else begin
      op_a = (PW/2)'($signed(gal_rdata)) - (PW/2)'($signed(qry_rdata));
      op_b = op_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      t1_q    <= tap0;
      t2_q    <= t1_q;
      t3_q    <= t2_q;
      if (state_q == S_RMETA) begin
        best_vld_q <= 1'b0;
      end else if (t3_q.vld && t3_q.last_e) begin
        best_vld_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    row_q <= row_d;
    e_q   <= e_d;
    n_q   <= n_d;
    if (meta_re) meta_vld_q <= valid_q[meta_raddr];
    if (t1_q.vld) prod_q <= op_a * op_b;
    if (t2_q.vld) acc_q <= t2_q.first_e ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    if (t3_q.vld && t3_q.last_e) best_q <= new_best;
    if (out_load) begin
      out_slot_q  <= out_slot_n;
      out_dist_q  <= out_dist_n;
      out_empty_q <= out_empty_n;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(gnfd_pkg::M_DATA_W - DW - gnfd_pkg::SLOT_W)'(0), out_dist_q,
                          out_slot_q};
  assign m_axis_tuser  = out_empty_q;

  gnfd_ram #(.WIDTH(MW), .DEPTH(MAX_TRACKS)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (TW'(cur_q.slot)),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  gnfd_ram #(.WIDTH(gnfd_pkg::VAL_W), .DEPTH(2 ** GAW)) u_gallery (
    .clk_i   (clk_i),
    .we_i    (gal_we),
    .waddr_i (gal_waddr),
    .wdata_i (cur_q.val),
    .re_i    (gal_re),
    .raddr_i (gal_raddr),
    .rdata_o (gal_rdata)
  );

  gnfd_ram #(.WIDTH(gnfd_pkg::VAL_W), .DEPTH(FEAT_DIM)) u_query (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (EW'(head_i.idx)),
    .wdata_i (head_i.val),
    .re_i    (gal_re),
    .raddr_i (e_q),
    .rdata_o (qry_rdata)
  );

  // A request leaves the queue only when the result register is free
  a_req_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.kind == gnfd_pkg::KIND_REQ) |-> !out_valid_q)
    else $error("request popped while result pending");

  // A result never overwrites one not yet taken
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("result register overwritten");

  // A gallery element finishes in the cycle after its metadata read
  a_gal_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GMETA) |=> (state_q == S_IDLE))
    else $error("gallery write did not complete");

  // Row scan stays within the rows in use
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (CW'(row_q) < n_q))
    else $error("row scan out of range");

endmodule

// ===== src/gallery_nearest_feature_distance.sv =====
// Nearest-gallery re-ID distance. Each track slot holds a ring of up to
// gallery_budget feature rows; a request returns the smallest distance
// (cosine 1 - dot, or squared euclidean) between the loaded query and all
// rows of that track, as signed Q5.30 saturated, with tuser set for an empty
// or out-of-range track. Items are queued in front of the execution unit.
// Query elements and drops complete in the idle state, gallery elements take
// a metadata read, then a write. A request holds the execution unit until its
// result is loaded: the single gallery memory read port delivers one element
// per cycle through a multiply-accumulate pipeline. Track metadata has
// per-slot valid bits, so no clearing pass runs after reset.
module gallery_nearest_feature_distance #(
  parameter int unsigned FEAT_DIM   = gnfd_pkg::FEAT_DIM_DEF,
  parameter int unsigned MAX_ROWS   = gnfd_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_TRACKS = gnfd_pkg::MAX_TRACKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [gnfd_pkg::BUDGET_W-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // track_slot[5:0], elem_index[14:6], element_value[30:15], zero[31]
  input  logic [gnfd_pkg::S_DATA_W-1:0] s_axis_tdata,
  // kind[1:0]
  input  logic [gnfd_pkg::KIND_W-1:0]   s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_slot[5:0], distance[41:6], zero[47:42]
  output logic [gnfd_pkg::M_DATA_W-1:0] m_axis_tdata,
  // gallery_empty[0]
  output logic                          m_axis_tuser
);

  gnfd_pkg::item_t head;
  logic            head_valid;
  logic            pop;

  gnfd_front #(.FEAT_DIM(FEAT_DIM), .MAX_TRACKS(MAX_TRACKS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .pop_i         (pop),
    .head_o        (head),
    .head_valid_o  (head_valid)
  );

  gnfd_back #(.FEAT_DIM(FEAT_DIM), .MAX_ROWS(MAX_ROWS), .MAX_TRACKS(MAX_TRACKS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
